// ----- hw/rtl/bit_matrix_transitive_closure_macros.svh -----
// Assertion macros used by the checker file of the transitive closure block.
`ifndef BIT_MATRIX_TRANSITIVE_CLOSURE_MACROS_SVH
`define BIT_MATRIX_TRANSITIVE_CLOSURE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BMTC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BMTC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/bmtc_pkg.sv -----
// Shared types and constants of the bit matrix transitive closure block.
package bmtc_pkg;

  localparam int ROW_W         = 64;
  localparam int IDX_W         = 6;
  localparam int SIZE_W        = 7;
  localparam int MAX_NODES_DEF = 64;
  localparam int IN_TDATA_W    = 72;
  localparam int OUT_TDATA_W   = 72;
  localparam int CFG_INDEX_W   = 1;

  localparam logic [CFG_INDEX_W-1:0] CFG_MATRIX_SIZE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_REFLEXIVE   = 1'b1;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_RUN  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLOSE,
    ST_READ
  } state_t;

  typedef struct packed {
    logic shift;
    logic closing;
    logic diag;
  } cell_ctl_t;

endpackage

// ----- hw/rtl/bmtc_cell.sv -----
// One cell of the row ring: holds one matrix row and hands its updated row onward.
module bmtc_cell (
  input  logic                       clk,
  input  bmtc_pkg::cell_ctl_t        ctl,
  input  logic                       load_sel,
  input  logic [bmtc_pkg::ROW_W-1:0] load_row,
  input  logic                       active,
  input  logic [bmtc_pkg::ROW_W-1:0] mask,
  input  logic [bmtc_pkg::ROW_W-1:0] cmask,
  input  logic [bmtc_pkg::ROW_W-1:0] pivot,
  input  logic [bmtc_pkg::ROW_W-1:0] next_row,
  output logic [bmtc_pkg::ROW_W-1:0] row_o,
  output logic [bmtc_pkg::ROW_W-1:0] upd_o
);
  import bmtc_pkg::*;

  logic [ROW_W-1:0] row_r;
  logic [ROW_W-1:0] row_nxt;
  logic [ROW_W-1:0] row_m;
  logic             hit;

  assign row_m = row_r & cmask;
  assign hit   = |(row_m & mask);
  assign row_o = row_r;

  always_comb begin
    if (ctl.closing) begin
      upd_o = row_m | (hit ? pivot : '0);
    end else begin
      upd_o = row_r | (ctl.diag ? mask : '0);
    end
  end

  always_comb begin
    if (load_sel) begin
      row_nxt = load_row;
    end else if (ctl.shift && active) begin
      row_nxt = next_row;
    end else begin
      row_nxt = row_r;
    end
  end

  always_ff @(posedge clk) begin
    row_r <= row_nxt;
  end

endmodule

// ----- hw/rtl/bit_matrix_transitive_closure.sv -----
// Top level of the bit matrix transitive closure block: control, configuration and cell ring.
//
// Input stream: in_tuser is the mode (0 loads a row, 1 runs the closure); in_tdata carries
// the row index and the row bits. A load transaction writes one row and is taken whenever
// the block is idle, so loads may arrive back to back. A run transaction closes rows 0 to
// n-1 by Warshall's rule and then streams them out, one output transaction per row, with
// out_tlast on row n-1. The rows sit in a ring of cells that rotates once per pivot during
// the closure; the readout rotates the ring a second time, one row per cycle while the
// receiver takes them. The first row is registered in the first readout step.
// in_tready stays low from a run until its last row has been registered.
// When out_tready is low with a row held, the output register keeps it and the readout stops.
// Synchronous reset sets matrix_size to 64 and reflexive to 1 and clears the state and the
// output valid flag; the row contents are undefined until loaded.
// Configuration writes on cfg_we take effect at once and belong to idle periods.
module bit_matrix_transitive_closure #(
  parameter int MAX_NODES = bmtc_pkg::MAX_NODES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // row_index [5:0], row_bits [69:6], zero [71:70]
  input  logic [bmtc_pkg::IN_TDATA_W-1:0]      in_tdata,
  // mode [0]
  input  logic                                 in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // out_row_index [5:0], out_row_bits [69:6], zero [71:70]
  output logic [bmtc_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                 out_tlast,
  input  logic                                 cfg_we,
  input  logic [bmtc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [bmtc_pkg::SIZE_W-1:0]          cfg_wdata
);
  import bmtc_pkg::*;

  state_t              state_r;
  state_t              state_nxt;
  cell_ctl_t           ctl;
  logic [SIZE_W-1:0]   matrix_size_r;
  logic                reflexive_r;
  logic [SIZE_W-1:0]   nodes_r;
  logic [ROW_W-1:0]    cmask_r;
  logic [ROW_W-1:0]    mask_r;
  logic [SIZE_W-1:0]   step_r;
  logic                out_valid_r;
  logic [IDX_W-1:0]    out_index_r;
  logic [ROW_W-1:0]    out_row_r;
  logic                out_last_r;

  logic                in_acc;
  logic                run_start;
  logic                adv;
  logic                emit;
  logic                last_step;
  logic [SIZE_W-1:0]   n_start;
  logic [ROW_W-1:0]    cmask_start;
  logic [IDX_W-1:0]    in_index;
  logic [ROW_W-1:0]    in_row;
  logic [ROW_W-1:0]    pivot;

  logic [ROW_W-1:0]    row_w [MAX_NODES];
  logic [ROW_W-1:0]    upd_w [MAX_NODES];

  assign in_index  = in_tdata[IDX_W-1:0];
  assign in_row    = in_tdata[IDX_W+ROW_W-1:IDX_W];
  assign in_acc    = in_tvalid && in_tready;
  assign run_start = in_acc && (in_tuser == MODE_RUN);
  assign adv       = !out_valid_r || out_tready;
  assign last_step = (step_r == nodes_r - SIZE_W'(1));
  assign pivot     = row_w[0] & cmask_r;

  always_comb begin
    if (matrix_size_r == '0) begin
      n_start = SIZE_W'(1);
    end else if (matrix_size_r > SIZE_W'(MAX_NODES)) begin
      n_start = SIZE_W'(MAX_NODES);
    end else begin
      n_start = matrix_size_r;
    end
    if (n_start >= SIZE_W'(ROW_W)) begin
      cmask_start = '1;
    end else begin
      cmask_start = (ROW_W'(1) << n_start) - ROW_W'(1);
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (run_start) begin
          state_nxt = ST_CLOSE;
        end
      end
      ST_CLOSE: begin
        if (last_step) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        if (adv && last_step) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl       = '0;
    in_tready = 1'b0;
    emit      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
      end
      ST_CLOSE: begin
        ctl.shift   = 1'b1;
        ctl.closing = 1'b1;
      end
      ST_READ: begin
        ctl.shift = adv;
        ctl.diag  = reflexive_r;
        emit      = adv;
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      matrix_size_r <= SIZE_W'(64);
      reflexive_r   <= 1'b1;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_MATRIX_SIZE: matrix_size_r <= cfg_wdata;
          CFG_REFLEXIVE:   reflexive_r   <= cfg_wdata[0];
          default:         reflexive_r   <= reflexive_r;
        endcase
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (run_start) begin
      nodes_r <= n_start;
      cmask_r <= cmask_start;
      step_r  <= '0;
      mask_r  <= ROW_W'(1);
    end else if (ctl.shift) begin
      if (last_step) begin
        step_r <= '0;
        mask_r <= ROW_W'(1);
      end else begin
        step_r <= step_r + SIZE_W'(1);
        mask_r <= mask_r << 1;
      end
    end
    if (emit) begin
      out_index_r <= step_r[IDX_W-1:0];
      out_row_r   <= upd_w[0];
      out_last_r  <= last_step;
    end
  end

  for (genvar i = 0; i < MAX_NODES; i++) begin : g_cell
    logic [ROW_W-1:0] next_row;
    logic             active;
    logic             tail;
    logic             load_sel;
    cell_ctl_t        cell_ctl;

    assign active   = (SIZE_W'(i) < nodes_r);
    assign tail     = (SIZE_W'(i) == nodes_r - SIZE_W'(1));
    assign load_sel = in_acc && (in_tuser == MODE_LOAD) && (in_index == IDX_W'(i));

    // Only the head cell holds the row being read out, so only it sets the diagonal.
    always_comb begin
      cell_ctl      = ctl;
      cell_ctl.diag = ctl.diag && (i == 0);
    end

    if (i == MAX_NODES - 1) begin : g_end
      assign next_row = upd_w[0];
    end else begin : g_mid
      assign next_row = tail ? upd_w[0] : upd_w[i+1];
    end

    bmtc_cell u_cell (
      .clk      (clk),
      .ctl      (cell_ctl),
      .load_sel (load_sel),
      .load_row (in_row),
      .active   (active),
      .mask     (mask_r),
      .cmask    (cmask_r),
      .pivot    (pivot),
      .next_row (next_row),
      .row_o    (row_w[i]),
      .upd_o    (upd_w[i])
    );
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {(OUT_TDATA_W-IDX_W-ROW_W)'(0), out_row_r, out_index_r};

endmodule

// ----- hw/rtl/bmtc_checker.sv -----
// Port-level checks of the bit matrix transitive closure block and their binding.
`include "bit_matrix_transitive_closure_macros.svh"

module bmtc_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              in_tuser,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [bmtc_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input logic                              out_tlast
);
  import bmtc_pkg::*;

  `BMTC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid, "output transaction dropped while stalled")
  `BMTC_ASSERT_NEXT(a_out_stable, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata) && $stable(out_tlast), "output payload changed while stalled")
  `BMTC_ASSERT_NEXT(a_run_busy, clk, rst_n, in_tvalid && in_tready && (in_tuser == MODE_RUN), !in_tready, "input still ready after a run transaction")
  `BMTC_ASSERT_SAME(a_idle_last, clk, rst_n, in_tready && out_tvalid, out_tlast, "pending output while idle is not the last row")

endmodule

bind bit_matrix_transitive_closure bmtc_checker u_bmtc_checker (.*);

// ----- dv/bit_matrix_transitive_closure_tb.sv -----
// Self-checking testbench for the transitive closure block: row loads, closure runs and readout.
`timescale 1ns / 100ps

module bit_matrix_transitive_closure_tb;
  import bmtc_pkg::*;

  localparam int ITEM_TARGET    = 420;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 8;
  localparam int TAIL_CYCLES    = 150;
  localparam int IDLE_PCT       = 19;
  localparam int PRINT_LIMIT    = 40;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic [ROW_W-1:0] bits;
    logic             last;
  } closed_row_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   in_tuser   = MODE_LOAD;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   cfg_we     = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index  = CFG_MATRIX_SIZE;
  logic [SIZE_W-1:0]      cfg_wdata  = '0;

  logic [ROW_W-1:0]  mirror_rows [MAX_NODES_DEF];
  logic [SIZE_W-1:0] mirror_size      = 7'd64;
  logic              mirror_reflexive = 1'b1;
  closed_row_t       closed_rows_q [$];

  logic [ROW_W-1:0] rows_defined = '0;
  bit               calm         = 1'b0;
  int unsigned      hold_asks    = 0;
  int unsigned      hold_seen    = 0;
  int unsigned      hold_left    = 0;
  int unsigned      quiet_cycles = 0;
  int unsigned      error_count  = 0;
  int unsigned      items_sent   = 0;
  int unsigned      loads_done   = 0;
  int unsigned      runs_done    = 0;
  int unsigned      rows_checked = 0;

  bit_matrix_transitive_closure uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  function automatic int nodes_used(input logic [SIZE_W-1:0] nodes_cfg);
    if (nodes_cfg == 0) return 1;
    if (nodes_cfg > MAX_NODES_DEF) return MAX_NODES_DEF;
    return int'(nodes_cfg);
  endfunction

  function automatic logic [ROW_W-1:0] columns_below(input int n);
    if (n >= ROW_W) return '1;
    return (64'd1 << n) - 64'd1;
  endfunction

  function automatic logic [ROW_W-1:0] random_row(input int n);
    logic [ROW_W-1:0] wide;
    wide = {$urandom, $urandom};
    case ($urandom_range(5))
      0: return 64'd1 << $urandom_range(n - 1);
      1, 2: return wide & {$urandom, $urandom} & columns_below(n);
      3: return wide & {$urandom, $urandom} & {$urandom, $urandom};
      4: return wide;
      default: return $urandom_range(1) ? '1 : '0;
    endcase
  endfunction

  function automatic void close_mirror();
    int n;
    logic [ROW_W-1:0] keep;
    n = nodes_used(mirror_size);
    keep = columns_below(n);
    for (int j = 0; j < n; j++) mirror_rows[j] &= keep;
    for (int k = 0; k < n; k++)
      for (int j = 0; j < n; j++)
        if (mirror_rows[j][k]) mirror_rows[j] |= mirror_rows[k];
    if (mirror_reflexive)
      for (int j = 0; j < n; j++) mirror_rows[j][j] = 1'b1;
    for (int j = 0; j < n; j++)
      closed_rows_q.push_back('{index: IDX_W'(j), bits: mirror_rows[j], last: (j == n - 1)});
  endfunction

  task automatic report_mismatch(input string what, input logic [ROW_W-1:0] got,
                                 input logic [ROW_W-1:0] want);
    error_count++;
    if (error_count <= PRINT_LIMIT)
      $display("%0t ns: %s mismatch after %0d rows: got %h, expected %h",
               $realtime, what, rows_checked, got, want);
  endtask

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      if (in_tuser == MODE_LOAD) begin
        mirror_rows[in_tdata[IDX_W-1:0]] = in_tdata[IDX_W +: ROW_W];
        loads_done++;
      end else begin
        close_mirror();
        runs_done++;
      end
    end
  end

  always @(posedge clk) begin
    closed_row_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (closed_rows_q.size() == 0) begin
        report_mismatch("unexpected row", out_tdata[IDX_W +: ROW_W], '0);
      end else begin
        want = closed_rows_q.pop_front();
        if (out_tdata[IDX_W-1:0] !== want.index)
          report_mismatch("row index", ROW_W'(out_tdata[IDX_W-1:0]), ROW_W'(want.index));
        if (out_tdata[IDX_W +: ROW_W] !== want.bits)
          report_mismatch("row bits", out_tdata[IDX_W +: ROW_W], want.bits);
        if (out_tlast !== want.last)
          report_mismatch("last flag", ROW_W'(out_tlast), ROW_W'(want.last));
        if (out_tdata[OUT_TDATA_W-1:IDX_W+ROW_W] !== '0)
          report_mismatch("padding", ROW_W'(out_tdata[OUT_TDATA_W-1:IDX_W+ROW_W]), '0);
        rows_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (hold_seen != hold_asks) begin
      hold_seen  <= hold_asks;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input logic mode, input logic [IDX_W-1:0] index,
                           input logic [ROW_W-1:0] bits);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {{(IN_TDATA_W - IDX_W - ROW_W){1'b0}}, bits, index};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic load_row(input logic [IDX_W-1:0] index, input logic [ROW_W-1:0] bits);
    send_item(MODE_LOAD, index, bits);
    rows_defined[index] = 1'b1;
  endtask

  // Rows in use must hold defined data before a run, so any gap is filled first.
  task automatic run_closure();
    int n;
    n = nodes_used(mirror_size);
    for (int j = 0; j < n; j++)
      if (!rows_defined[j]) load_row(IDX_W'(j), random_row(n));
    send_item(MODE_RUN, IDX_W'($urandom), {$urandom, $urandom});
    rows_defined |= columns_below(n);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (closed_rows_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_config(input logic [SIZE_W-1:0] nodes_cfg, input logic refl);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MATRIX_SIZE;
    cfg_wdata <= nodes_cfg;
    @(posedge clk);
    cfg_index <= CFG_REFLEXIVE;
    cfg_wdata <= SIZE_W'(refl);
    @(posedge clk);
    cfg_we <= 1'b0;
    mirror_size      = nodes_cfg;
    mirror_reflexive = refl;
  endtask

  task automatic test_reset_defaults();
    calm = 1'b1;
    for (int j = 0; j < MAX_NODES_DEF; j++)
      load_row(IDX_W'(j), (j == MAX_NODES_DEF - 1) ? 64'd0 : (64'd1 << (j + 1)));
    run_closure();
    settle();
    calm = 1'b0;
  endtask

  task automatic test_edge_cases();
    program_config(7'd1, 1'b0);
    load_row(6'd0, '1);
    run_closure();
    settle();
    program_config(7'd0, 1'b1);
    run_closure();
    settle();
    program_config(7'd2, 1'b0);
    load_row(6'd0, 64'h2);
    load_row(6'd1, 64'h1);
    run_closure();
    run_closure();
    settle();
    program_config(7'd3, 1'b1);
    load_row(6'd0, '0);
    load_row(6'd1, '0);
    load_row(6'd2, '0);
    run_closure();
    settle();
    program_config(7'd127, 1'b0);
    load_row(6'd63, '1);
    load_row(6'd0, 64'h8000_0000_0000_0000);
    run_closure();
    settle();
  endtask

  task automatic test_backpressure();
    program_config(7'd16, 1'b1);
    for (int j = 0; j < 16; j++) load_row(IDX_W'(j), random_row(16));
    hold_asks++;
    run_closure();
    repeat (20) load_row(IDX_W'($urandom), random_row(16));
    run_closure();
    settle();
    run_closure();
    settle();
  endtask

  task automatic test_random_closures();
    int n;
    int runs;
    int pick;
    int swap;
    int order [MAX_NODES_DEF];
    int roll;
    logic [SIZE_W-1:0] nodes_cfg;
    while (items_sent < ITEM_TARGET) begin
      roll = $urandom_range(99);
      if (roll < 65) nodes_cfg = SIZE_W'($urandom_range(8, 1));
      else if (roll < 87) nodes_cfg = SIZE_W'($urandom_range(20, 9));
      else if (roll < 92) nodes_cfg = 7'd64;
      else if (roll < 96) nodes_cfg = 7'd0;
      else nodes_cfg = SIZE_W'($urandom_range(127, 65));
      program_config(nodes_cfg, 1'($urandom));
      n = nodes_used(nodes_cfg);
      runs = (n > 20) ? 1 : $urandom_range(3, 1);
      repeat (runs) begin
        if ($urandom_range(3) != 0) begin
          for (int j = 0; j < n; j++) order[j] = j;
          for (int j = n - 1; j > 0; j--) begin
            pick = $urandom_range(j);
            swap = order[j];
            order[j] = order[pick];
            order[pick] = swap;
          end
          for (int j = 0; j < n; j++) begin
            load_row(IDX_W'(order[j]), random_row(n));
            if (n < MAX_NODES_DEF && $urandom_range(9) == 0)
              load_row(IDX_W'($urandom_range(MAX_NODES_DEF - 1, n)), random_row(MAX_NODES_DEF));
          end
        end else if ($urandom_range(1) != 0) begin
          load_row(IDX_W'($urandom_range(n - 1)), random_row(n));
        end
        run_closure();
      end
      settle();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_edge_cases();
    test_backpressure();
    test_random_closures();
    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (closed_rows_q.size() != 0)
      report_mismatch("missing rows", ROW_W'(closed_rows_q.size()), '0);
    $display("Sent %0d row loads and %0d closure runs; %0d closed rows were checked.",
             loads_done, runs_done, rows_checked);
    $display("Sizes ranged from one node to the full 64, out-of-range settings included.");
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
